// ----- rtl/core/varma_pkg.sv -----
// ============================================================================
// varma_pkg - shared types and constants for the vector ARMA(2,2) filter
// Word layout, table geometry, fixed-point formats and command codes.
// ============================================================================
`default_nettype none

package varma_pkg;

    // Packed vector word layout
    localparam int LANE_BITS       = 16;
    localparam int MAX_DIM         = 4;
    localparam int VEC_BITS        = LANE_BITS * MAX_DIM;

    // Coefficient table: Phi0, Phi1, Theta0, Theta1
    localparam int NUM_MATRICES    = 4;
    localparam int MAT_PHI0        = 0;
    localparam int MAT_PHI1        = 1;
    localparam int MAT_THETA0      = 2;
    localparam int MAT_THETA1      = 3;
    localparam int TABLE_DEPTH     = NUM_MATRICES * MAX_DIM * MAX_DIM;
    localparam int INDEX_BITS      = $clog2(TABLE_DEPTH);
    localparam int COEF_FIELD_BITS = 18;

    // Coefficient fraction bits (Q2.15 at full width)
    localparam int FRAC_COEF       = 15;

    // Parameter defaults for the core
    localparam int DEF_DIM         = 4;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_COEF_BITS   = 18;

    // Warmup: outputs stay zero until this many samples of a sequence
    localparam int WARM_BITS       = 2;
    localparam int WARM_SAMPLES    = 2;

    typedef logic [VEC_BITS-1:0] vector_t;

    typedef enum logic {
        CMD_SAMPLE     = 1'b0,
        CMD_COEF_WRITE = 1'b1
    } command_t;

endpackage : varma_pkg

`default_nettype wire

// ----- rtl/core/varma_stream_if.sv -----
// ============================================================================
// varma_stream_if - valid/ready channels of the vector ARMA(2,2) filter
// Input channel carries sample and coefficient words, result channel carries
// the filtered vector and its saturation flag.
// ============================================================================
`default_nettype none

interface varma_item_if;
    import varma_pkg::*;

    logic                               valid;
    logic                               ready;
    command_t                           command;
    logic                               start_req;
    logic        [INDEX_BITS-1:0]       coef_index;
    logic signed [COEF_FIELD_BITS-1:0]  coef_value;
    vector_t                            noise_vector;

    modport source (
        output valid, command, start_req, coef_index, coef_value, noise_vector,
        input  ready
    );

    modport sink (
        input  valid, command, start_req, coef_index, coef_value, noise_vector,
        output ready
    );
endinterface : varma_item_if

interface varma_result_if;
    import varma_pkg::*;

    logic    valid;
    logic    ready;
    vector_t process_vector;
    logic    overflow;

    modport source (
        output valid, process_vector, overflow,
        input  ready
    );

    modport sink (
        input  valid, process_vector, overflow,
        output ready
    );
endinterface : varma_result_if

`default_nettype wire

// ----- rtl/core/varma_2_2_vector_filter_core.sv -----
// ============================================================================
// varma_2_2_vector_filter_core - vector ARMA(2,2) filter, one word per cycle unless stalled
// A sample word passes the input register, then the result register, on to the result channel.
// Throughput: 1 word per cycle while no sample waits on a full result register; the x feedback
//   loop (DIM*DIM*4 parallel multipliers and a row adder tree) is computed in one stage.
// Reset clears the coefficient table, the x/z history and the warmup count.
// ============================================================================
`default_nettype none

module varma_2_2_vector_filter_core #(
    parameter int DIM         = varma_pkg::DEF_DIM,
    parameter int SAMPLE_BITS = varma_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_BITS   = varma_pkg::DEF_COEF_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    varma_item_if.sink     item,
    varma_result_if.source result
);
    import varma_pkg::*;

    localparam int PROD_BITS  = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_BITS   = PROD_BITS + 5;
    localparam int TABLE_USED = NUM_MATRICES * DIM * DIM;

    localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
        ACC_BITS'(1) <<< (FRAC_COEF - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_MAX =
        (ACC_BITS'(1) <<< (SAMPLE_BITS - 1)) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] SAT_MIN =
        -(ACC_BITS'(1) <<< (SAMPLE_BITS - 1));

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;

    // Input register
    logic                  s1_valid_reg;
    command_t              s1_cmd_reg;
    logic                  s1_start_reg;
    logic [INDEX_BITS-1:0] s1_index_reg;
    coef_t                 s1_coef_reg;
    sample_t               s1_noise_reg [DIM];

    // Filter state
    coef_t                 coef_reg [TABLE_DEPTH];
    sample_t               x1_reg [DIM];
    sample_t               x2_reg [DIM];
    sample_t               z1_reg [DIM];
    sample_t               z2_reg [DIM];
    logic [WARM_BITS-1:0]  warm_reg;
    logic [WARM_BITS-1:0]  warm_next;

    // Result register
    logic                  out_valid_reg;
    vector_t               out_vector_reg;
    logic                  out_ovf_reg;

    // Datapath
    logic                  s1_go;
    logic                  sample_go;
    logic                  coef_go;
    logic [WARM_BITS-1:0]  warm_eff;
    logic                  running;
    sample_t               x_lane [DIM];
    vector_t               x_vector;
    logic                  x_ovf;

    // ------------------------------------------------------------------------
    // Handshake: the input stage moves on unless a sample is blocked by a
    // full, unread result register. Coefficient words never wait.
    // ------------------------------------------------------------------------
    assign s1_go      = s1_valid_reg &&
                        ((s1_cmd_reg == CMD_COEF_WRITE) || !out_valid_reg || result.ready);
    assign sample_go  = s1_go && (s1_cmd_reg == CMD_SAMPLE);
    assign coef_go    = s1_go && (s1_cmd_reg == CMD_COEF_WRITE);
    assign item.ready = !s1_valid_reg || s1_go;

    assign result.valid          = out_valid_reg;
    assign result.process_vector = out_vector_reg;
    assign result.overflow       = out_ovf_reg;

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_cmd_reg   <= item.command;
            s1_start_reg <= item.start_req;
            s1_index_reg <= item.coef_index;
            s1_coef_reg  <= item.coef_value[COEF_BITS-1:0];
            for (int i = 0; i < DIM; i++)
            begin
                s1_noise_reg[i] <= item.noise_vector[i*LANE_BITS +: SAMPLE_BITS];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Warmup: a start flag restarts the count; the first two samples of a
    // sequence give a zero result.
    // ------------------------------------------------------------------------
    always_comb
    begin
        warm_eff  = s1_start_reg ? '0 : warm_reg;
        running   = (warm_eff == WARM_BITS'(WARM_SAMPLES));
        warm_next = running ? warm_eff : warm_eff + WARM_BITS'(1);
    end

    // ------------------------------------------------------------------------
    // Row sums: x = Phi0*x1 + Phi1*x2 + z + Theta0*z1 + Theta1*z2, then
    // round half up, saturate (zero during warmup), and pack.
    // ------------------------------------------------------------------------
    always_comb
    begin
        logic signed [PROD_BITS-1:0] p_phi0;
        logic signed [PROD_BITS-1:0] p_phi1;
        logic signed [PROD_BITS-1:0] p_th0;
        logic signed [PROD_BITS-1:0] p_th1;
        logic signed [ACC_BITS-1:0]  col_sum;
        logic signed [ACC_BITS-1:0]  acc;
        logic signed [ACC_BITS-1:0]  rounded;

        x_ovf    = 1'b0;
        x_vector = '0;
        for (int r = 0; r < DIM; r++)
        begin
            acc = ACC_BITS'(s1_noise_reg[r]) <<< FRAC_COEF;
            for (int c = 0; c < DIM; c++)
            begin
                p_phi0 = PROD_BITS'(coef_reg[INDEX_BITS'(MAT_PHI0*DIM*DIM + r*DIM + c)])
                       * PROD_BITS'(x1_reg[c]);
                p_phi1 = PROD_BITS'(coef_reg[INDEX_BITS'(MAT_PHI1*DIM*DIM + r*DIM + c)])
                       * PROD_BITS'(x2_reg[c]);
                p_th0  = PROD_BITS'(coef_reg[INDEX_BITS'(MAT_THETA0*DIM*DIM + r*DIM + c)])
                       * PROD_BITS'(z1_reg[c]);
                p_th1  = PROD_BITS'(coef_reg[INDEX_BITS'(MAT_THETA1*DIM*DIM + r*DIM + c)])
                       * PROD_BITS'(z2_reg[c]);
                col_sum = (ACC_BITS'(p_phi0) + ACC_BITS'(p_phi1))
                        + (ACC_BITS'(p_th0) + ACC_BITS'(p_th1));
                acc = acc + col_sum;
            end
            rounded = (acc + ROUND_HALF) >>> FRAC_COEF;

            if (!running)
            begin
                x_lane[r] = '0;
            end
            else if (rounded > SAT_MAX)
            begin
                x_lane[r] = SAT_MAX[SAMPLE_BITS-1:0];
                x_ovf     = 1'b1;
            end
            else if (rounded < SAT_MIN)
            begin
                x_lane[r] = SAT_MIN[SAMPLE_BITS-1:0];
                x_ovf     = 1'b1;
            end
            else
            begin
                x_lane[r] = rounded[SAMPLE_BITS-1:0];
            end
            x_vector[r*LANE_BITS +: LANE_BITS] = LANE_BITS'(x_lane[r]);
        end
    end

    // Coefficient table; writes past the used matrices are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (coef_go && (int'(s1_index_reg) < TABLE_USED))
        begin
            coef_reg[s1_index_reg] <= s1_coef_reg;
        end
    end

    // History shift; a start flag clears the older entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_reg <= '0;
            for (int i = 0; i < DIM; i++)
            begin
                x1_reg[i] <= '0;
                x2_reg[i] <= '0;
                z1_reg[i] <= '0;
                z2_reg[i] <= '0;
            end
        end
        else if (sample_go)
        begin
            warm_reg <= warm_next;
            for (int i = 0; i < DIM; i++)
            begin
                x1_reg[i] <= x_lane[i];
                x2_reg[i] <= s1_start_reg ? '0 : x1_reg[i];
                z1_reg[i] <= s1_noise_reg[i];
                z2_reg[i] <= s1_start_reg ? '0 : z1_reg[i];
            end
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sample_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (sample_go)
        begin
            out_vector_reg <= x_vector;
            out_ovf_reg    <= x_ovf;
        end
    end

endmodule : varma_2_2_vector_filter_core

`default_nettype wire

// ----- test/varma_2_2_vector_filter_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// varma_2_2_vector_filter_checker - scoreboard for the vector ARMA(2,2) filter
// Watches both channels, keeps its own copy of the coefficient table and the
// x/z history, predicts the result word of every accepted sample word and
// compares it field by field with the words leaving the result channel.
// ============================================================================

module varma_2_2_vector_filter_checker #(
    parameter int DIM         = varma_pkg::DEF_DIM,
    parameter int SAMPLE_BITS = varma_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_BITS   = varma_pkg::DEF_COEF_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    varma_item_if    item,
    varma_result_if  result,
    output int       mismatch_count,
    output int       results_pending
);
    import varma_pkg::*;

    typedef struct packed {
        vector_t process_vector;
        logic    overflow;
    } filter_result_t;

    // Mirrored filter state
    longint         coef_tbl [TABLE_DEPTH];
    vector_t        x_hist_1;
    vector_t        x_hist_2;
    vector_t        z_hist_1;
    vector_t        z_hist_2;
    int             warm_count;

    filter_result_t expected_results [$];

    // Keep the low bits and sign-extend
    function automatic longint sign_extend(longint raw, int bits);
        longint v;
        v = raw & ((longint'(1) << bits) - 1);
        if (((v >> (bits - 1)) & 1) != 0)
            v = v - (longint'(1) << bits);
        return v;
    endfunction

    function automatic longint lane_value(vector_t packed_vec, int lane);
        logic [LANE_BITS-1:0] raw;
        raw = packed_vec[lane*LANE_BITS +: LANE_BITS];
        return sign_extend(longint'(raw), SAMPLE_BITS);
    endfunction

    function automatic longint coef_at(int mat, int row, int col);
        return coef_tbl[(mat * DIM * DIM + row * DIM + col) % TABLE_DEPTH];
    endfunction

    // One sample word: update the history and queue the expected result
    task automatic filter_sample(input logic restart, input vector_t noise);
        vector_t        z;
        vector_t        x;
        logic           ovf;
        longint         acc;
        longint         v;
        longint         max_val;
        longint         min_val;
        filter_result_t res;
        z       = '0;
        x       = '0;
        ovf     = 1'b0;
        max_val = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        min_val = -(longint'(1) << (SAMPLE_BITS - 1));
        if (restart)
        begin
            x_hist_1   = '0;
            x_hist_2   = '0;
            z_hist_1   = '0;
            z_hist_2   = '0;
            warm_count = 0;
        end
        for (int i = 0; i < DIM; i++)
        begin
            v = lane_value(noise, i);
            z[i*LANE_BITS +: LANE_BITS] = v[LANE_BITS-1:0];
        end
        if (warm_count >= WARM_SAMPLES)
        begin
            for (int r = 0; r < DIM; r++)
            begin
                acc = lane_value(z, r) * (longint'(1) << FRAC_COEF);
                for (int c = 0; c < DIM; c++)
                begin
                    acc += coef_at(MAT_PHI0, r, c) * lane_value(x_hist_1, c);
                    acc += coef_at(MAT_PHI1, r, c) * lane_value(x_hist_2, c);
                    acc += coef_at(MAT_THETA0, r, c) * lane_value(z_hist_1, c);
                    acc += coef_at(MAT_THETA1, r, c) * lane_value(z_hist_2, c);
                end
                // round half up, floor shift
                v = (acc + (longint'(1) << (FRAC_COEF - 1))) >>> FRAC_COEF;
                if (v > max_val)
                begin
                    v   = max_val;
                    ovf = 1'b1;
                end
                else if (v < min_val)
                begin
                    v   = min_val;
                    ovf = 1'b1;
                end
                x[r*LANE_BITS +: LANE_BITS] = v[LANE_BITS-1:0];
            end
        end
        else
        begin
            warm_count++;
        end
        x_hist_2 = x_hist_1;
        x_hist_1 = x;
        z_hist_2 = z_hist_1;
        z_hist_1 = z;
        res.process_vector = x;
        res.overflow       = ovf;
        expected_results.push_back(res);
    endtask

    // Monitor both channels
    always @(posedge clk or negedge rst_n)
    begin
        filter_result_t want;
        if (!rst_n)
        begin
            foreach (coef_tbl[i])
                coef_tbl[i] = 0;
            x_hist_1   = '0;
            x_hist_2   = '0;
            z_hist_1   = '0;
            z_hist_2   = '0;
            warm_count = 0;
            expected_results.delete();
            mismatch_count  = 0;
            results_pending <= 0;
        end
        else
        begin
            // accepted input word
            if (item.valid && item.ready)
            begin
                if (item.command == CMD_COEF_WRITE)
                begin
                    if (int'(item.coef_index) < NUM_MATRICES * DIM * DIM)
                        coef_tbl[item.coef_index] =
                            sign_extend(longint'(item.coef_value), COEF_BITS);
                end
                else
                begin
                    filter_sample(item.start_req, item.noise_vector);
                end
            end
            // accepted result word
            if (result.valid && result.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: process_vector %h overflow %b",
                             $time, result.process_vector, result.overflow);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.process_vector !== want.process_vector)
                    begin
                        $display("%0t: process_vector expected %h actual %h",
                                 $time, want.process_vector, result.process_vector);
                        mismatch_count++;
                    end
                    if (result.overflow !== want.overflow)
                    begin
                        $display("%0t: overflow expected %b actual %b",
                                 $time, want.overflow, result.overflow);
                        mismatch_count++;
                    end
                end
            end
            results_pending <= expected_results.size();
        end
    end

endmodule : varma_2_2_vector_filter_checker

// ----- test/varma_2_2_vector_filter_core_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// varma_2_2_vector_filter_core_tb - regression for the vector ARMA(2,2) core
// Drives coefficient and sample words in random bursts, with directed corner
// words first, then random sequences over several coefficient styles. The
// result side stalls on its own pattern, including one long hold-off. The
// checker beside the core predicts and compares every result word.
// ============================================================================

module varma_2_2_vector_filter_core_tb;
    import varma_pkg::*;

    localparam int NUM_PHASES        = 6;
    localparam int HOLD_PHASE        = 2;
    localparam int SAMPLES_PER_PHASE = 60;
    localparam int LONG_HOLD_CYCLES  = 200;
    localparam int DRAIN_TAIL        = 10;

    localparam logic signed [COEF_FIELD_BITS-1:0] COEF_MAX = 18'sh1FFFF;
    localparam logic signed [COEF_FIELD_BITS-1:0] COEF_MIN = 18'sh20000;

    typedef enum int {
        COEF_ZERO,
        COEF_SMALL,
        COEF_FULL,
        COEF_EXTREME
    } coef_style_t;

    typedef enum int {
        NOISE_FULL,
        NOISE_SMALL,
        NOISE_EXTREME,
        NOISE_MIXED
    } noise_style_t;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   results_pending;
    int   holds_requested;
    int   burst_left;
    bit   no_gaps;

    varma_item_if   item_ch ();
    varma_result_if result_ch ();

    varma_2_2_vector_filter_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    varma_2_2_vector_filter_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item_ch),
        .result          (result_ch),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int coef_slot(int mat, int row, int col);
        return mat * DEF_DIM * DEF_DIM + row * DEF_DIM + col;
    endfunction

    function automatic logic signed [COEF_FIELD_BITS-1:0] coef_for_style(coef_style_t style);
        int v;
        case (style)
            COEF_SMALL:   v = int'($urandom_range(0, 6000)) - 3000;
            COEF_FULL:    v = int'($urandom);
            COEF_EXTREME:
            begin
                case ($urandom_range(0, 3))
                    0:       v = int'(COEF_MAX);
                    1:       v = int'(COEF_MIN);
                    2:       v = -1;
                    default: v = 0;
                endcase
            end
            default:      v = 0;
        endcase
        return v[COEF_FIELD_BITS-1:0];
    endfunction

    function automatic vector_t noise_for_style(noise_style_t style);
        vector_t nv;
        int      v;
        nv = {$urandom, $urandom};
        if (style != NOISE_FULL)
        begin
            for (int i = 0; i < MAX_DIM; i++)
            begin
                if (style == NOISE_SMALL || (style == NOISE_MIXED && $urandom_range(0, 1)))
                    v = int'($urandom_range(0, 4095)) - 2048;
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       v = 32'h7FFF;
                        1:       v = 32'h8000;
                        2:       v = -1;
                        default: v = 0;
                    endcase
                end
                nv[i*LANE_BITS +: LANE_BITS] = v[LANE_BITS-1:0];
            end
        end
        return nv;
    endfunction

    // Offer one word and hold it until the core takes it
    task automatic send_word(input command_t cmd, input logic restart,
                             input logic [INDEX_BITS-1:0] idx,
                             input logic signed [COEF_FIELD_BITS-1:0] val,
                             input vector_t noise);
        int gap;
        if (burst_left <= 0)
        begin
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        item_ch.valid        <= 1'b1;
        item_ch.command      <= cmd;
        item_ch.start_req    <= restart;
        item_ch.coef_index   <= idx;
        item_ch.coef_value   <= val;
        item_ch.noise_vector <= noise;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        burst_left--;
    endtask

    // Sample word with junk in the unused fields
    task automatic send_sample(input logic restart, input vector_t noise);
        send_word(CMD_SAMPLE, restart, INDEX_BITS'($urandom), COEF_FIELD_BITS'($urandom),
                  noise);
    endtask

    // Coefficient write with a random start flag and noise
    task automatic send_coef(input int idx, input logic signed [COEF_FIELD_BITS-1:0] val);
        send_word(CMD_COEF_WRITE, 1'($urandom), INDEX_BITS'(idx), val, {$urandom, $urandom});
    endtask

    // Stop offering and wait until every result word is back
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
    endtask

    // Result side stall pattern
    initial
    begin
        int cycle_count;
        int holds_done;
        cycle_count = 0;
        holds_done  = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done < holds_requested)
            begin
                // long hold-off so the core backs up into its input
                holds_done++;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                case ((cycle_count / 50) % 4)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= cycle_count[2];
                endcase
                cycle_count++;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        coef_style_t  style;
        noise_style_t noise_style;
        int           samples_left;
        int           seq_len;
        int           k;
        logic         restart;

        rst_n                <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.command      <= CMD_SAMPLE;
        item_ch.start_req    <= 1'b0;
        item_ch.coef_index   <= '0;
        item_ch.coef_value   <= '0;
        item_ch.noise_vector <= '0;
        holds_requested      <= 0;
        burst_left = 0;
        no_gaps    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight out of reset, no start flag; warmup zeros, then the zero table gives x = z
        send_sample(1'b0, 64'h7FFF_8000_FFFF_0000);
        send_sample(1'b0, 64'h8000_7FFF_0001_FFFF);
        send_sample(1'b0, 64'h7FFF_7FFF_7FFF_7FFF);
        send_sample(1'b0, 64'h8000_8000_8000_8000);

        // Table extremes; start flag on a write has no effect
        send_word(CMD_COEF_WRITE, 1'b1, INDEX_BITS'(coef_slot(MAT_PHI0, 0, 0)), COEF_MAX,
                  64'hFFFF_FFFF_FFFF_FFFF);
        send_coef(coef_slot(MAT_PHI0, 1, 1), COEF_MIN);
        send_coef(TABLE_DEPTH - 1, COEF_MAX);
        send_coef(coef_slot(MAT_PHI1, 0, 0), -18'sd16384);
        send_coef(coef_slot(MAT_THETA0, 2, 2), 18'sd16384);
        send_coef(coef_slot(MAT_THETA1, 2, 3), -18'sd1);
        send_coef(coef_slot(MAT_PHI0, 3, 0), 18'sd32767);

        // New sequence: warmup zeros, then saturating outputs
        send_sample(1'b1, 64'h7FFF_8000_7FFF_8000);
        send_sample(1'b0, 64'h8000_7FFF_8000_7FFF);
        send_sample(1'b0, 64'h7FFF_7FFF_7FFF_7FFF);
        send_sample(1'b0, 64'h8000_8000_8000_8000);
        send_sample(1'b0, 64'h0000_FFFF_0001_7FFF);
        send_sample(1'b0, 64'h0000_0000_0000_0000);

        // Restart in the middle of a sequence
        send_sample(1'b1, 64'h1234_5678_9ABC_DEF0);
        send_sample(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_sample(1'b0, 64'h0001_0001_0001_0001);

        // Random phases, one coefficient style each
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                1:       style = COEF_FULL;
                3:       style = COEF_EXTREME;
                4:       style = COEF_ZERO;
                default: style = COEF_SMALL;
            endcase
            drain_results();

            if (style == COEF_ZERO)
            begin
                for (int idx = 0; idx < TABLE_DEPTH; idx++)
                    send_coef(idx, '0);
            end
            else
            begin
                repeat (20)
                    send_coef($urandom_range(0, TABLE_DEPTH - 1), coef_for_style(style));
            end

            if (phase == HOLD_PHASE)
            begin
                holds_requested <= holds_requested + 1;
                no_gaps = 1'b1;
            end

            samples_left = SAMPLES_PER_PHASE;
            while (samples_left > 0)
            begin
                seq_len     = $urandom_range(3, 25);
                noise_style = noise_style_t'($urandom_range(0, 3));
                k = 0;
                while (k < seq_len && samples_left > 0)
                begin
                    // stray coefficient write inside a sequence
                    if (k > 0 && $urandom_range(0, 29) == 0)
                        send_coef($urandom_range(0, TABLE_DEPTH - 1), coef_for_style(style));
                    if (k == 0)
                        restart = ($urandom_range(0, 9) != 0);
                    else
                        restart = ($urandom_range(0, 39) == 0);
                    send_sample(restart, noise_for_style(noise_style));
                    samples_left--;
                    k++;
                end
            end
            no_gaps = 1'b0;
        end

        drain_results();
        repeat (DRAIN_TAIL) @(posedge clk);

        if (mismatch_count == 0 && results_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule : varma_2_2_vector_filter_core_tb

// ----- filelist.f -----
rtl/core/varma_pkg.sv
rtl/core/varma_stream_if.sv
rtl/core/varma_2_2_vector_filter_core.sv
test/varma_2_2_vector_filter_checker.sv
test/varma_2_2_vector_filter_core_tb.sv
